>>> design/ffca_pkg.sv
// Package of the first-fit coalescing allocator: default sizes, result codes
// and the sequencer state type. It depends on nothing else.
package ffca_pkg;

  localparam int unsigned DEF_HEAP_WORDS    = 4096;
  localparam int unsigned DEF_TABLE_ENTRIES = 64;
  localparam int unsigned DEF_WORD_BYTES    = 8;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_USED_FULL = 3'd1,
    STAT_ZERO_SIZE = 3'd2,
    STAT_EXCEEDED  = 3'd3,
    STAT_NO_FIT    = 3'd4,
    STAT_UNKNOWN   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_FIT,
    FSM_TRIM,
    FSM_HREM,
    FSM_UPOS,
    FSM_UINS,
    FSM_FADDR,
    FSM_UREM,
    FSM_HPOS,
    FSM_MERGE,
    FSM_HINS,
    FSM_RESP
  } fsm_t;

endpackage

>>> design/first_fit_coalescing_allocator_core.sv
// First-fit word heap allocator with a coalescing hole table; uses ffca_pkg and ffca_ram.
// An allocate scans the hole table for the first hole that fits, trims it or removes it
// when used up exactly, then scans the used table for the new block's place and inserts
// it. A free finds and removes its block in the used table, then finds its place in the
// hole table and merges it with its neighbours or, if there is room, inserts a new hole.
// A request that fails a check is answered with no table scan, an unknown free address
// after a scan of the used table. One request is taken at a time; the next beat is taken
// in the cycle after the result is raised. Each table has one read and one write port.
// Reset: synchronous, active low; it empties the used table and restores the one hole over
// the whole heap at once (entry 0 of the hole table carries a valid bit), no clearing pass.
module first_fit_coalescing_allocator_core
  import ffca_pkg::*;
#(
  parameter int unsigned HEAP_WORDS    = DEF_HEAP_WORDS,
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned WORD_BYTES    = DEF_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[15:0], block_start[27:16], zeros above
  input  logic        in_tuser,   // command: 0 allocate, 1 free
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[2:0], granted_start[14:3], words_used[27:15]
);

  // Start addresses and lengths are held at the widths the heap size needs.
  localparam int unsigned SW   = $clog2(HEAP_WORDS);
  localparam int unsigned LW   = $clog2(HEAP_WORDS + 1);
  localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW   = SW + LW;
  localparam int unsigned AXW  = (SW > 12) ? SW : 12;
  localparam int unsigned CMPW = ((LW > 16) ? LW : 16) + 1;

  fsm_t             state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [11:0]      addr_r, addr_nxt;
  logic [15:0]      words_r, words_nxt;
  logic [SW-1:0]    key_r, key_nxt;        // start word of the block in hand
  logic [LW-1:0]    len_r, len_nxt;        // length of the block in hand
  logic [LW-1:0]    hlen_r, hlen_nxt;      // length of the hole that fitted
  logic [CW-1:0]    uc_r, uc_nxt;
  logic [CW-1:0]    hc_r, hc_nxt;
  logic [LW-1:0]    wiu_r, wiu_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    p_r, p_nxt;
  logic [SW-1:0]    cur_s_r, cur_s_nxt, prev_s_r, prev_s_nxt;
  logic [LW-1:0]    cur_l_r, cur_l_nxt, prev_l_r, prev_l_nxt;
  logic             has_cur_r, has_cur_nxt, has_prev_r, has_prev_nxt;
  logic             h0v_r, h0v_nxt;
  logic             hz_q_r;
  status_t          status_r, status_nxt;
  logic [SW-1:0]    granted_r, granted_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  // Shared access port of the sequencer, steered to one of the two tables.
  logic             sel_hole;
  logic             rd_en, wr_en;
  logic [CW-1:0]    rd_idx, wr_idx;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    used_q, hole_ram_q, hole_q, rdata;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    rs;
  logic [LW-1:0]    rl;
  logic             issue, hit;
  logic             right_m, left_m;
  logic [16:0]      bsum;
  logic [15:0]      words_in;

  assign bsum     = 17'(in_tdata[15:0]) + 17'(WORD_BYTES - 1);
  assign words_in = 16'(bsum / WORD_BYTES);

  ffca_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_used_ram (
    .clk   (clk),
    .we    (wr_en && !sel_hole),
    .waddr (wr_idx[IW-1:0]),
    .wdata (wr_data),
    .raddr (rd_idx[IW-1:0]),
    .rdata (used_q)
  );

  ffca_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_hole_ram (
    .clk   (clk),
    .we    (wr_en && sel_hole),
    .waddr (wr_idx[IW-1:0]),
    .wdata (wr_data),
    .raddr (rd_idx[IW-1:0]),
    .rdata (hole_ram_q)
  );

  // Until entry 0 of the hole table is first written it reads as the whole-heap hole.
  assign hole_q = (hz_q_r && !h0v_r) ? {SW'(0), LW'(HEAP_WORDS)} : hole_ram_q;

  always_comb begin
    sel_hole = (state_r == FSM_FIT) || (state_r == FSM_TRIM) || (state_r == FSM_HREM) ||
               (state_r == FSM_HPOS) || (state_r == FSM_MERGE) || (state_r == FSM_HINS);
  end

  assign cnt   = sel_hole ? hc_r : uc_r;
  assign rdata = sel_hole ? hole_q : used_q;
  assign rs    = rdata[EW-1:LW];
  assign rl    = rdata[LW-1:0];

  assign in_tready  = (state_r == FSM_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      uc_r        <= '0;
      hc_r        <= CW'(1);
      wiu_r       <= '0;
      pend_r      <= 1'b0;
      h0v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uc_r        <= uc_nxt;
      hc_r        <= hc_nxt;
      wiu_r       <= wiu_nxt;
      pend_r      <= pend_nxt;
      h0v_r       <= h0v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    words_r    <= words_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    hlen_r     <= hlen_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    p_r        <= p_nxt;
    cur_s_r    <= cur_s_nxt;
    cur_l_r    <= cur_l_nxt;
    prev_s_r   <= prev_s_nxt;
    prev_l_r   <= prev_l_nxt;
    has_cur_r  <= has_cur_nxt;
    has_prev_r <= has_prev_nxt;
    hz_q_r     <= (rd_idx[IW-1:0] == '0);
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    out_data_r <= out_data_nxt;
  end

  // Merge tests against the neighbouring holes found by the position scan.
  assign right_m = has_cur_r &&
                   ((LW+1)'(key_r) + (LW+1)'(len_r) == (LW+1)'(cur_s_r));
  assign left_m  = has_prev_r &&
                   ((LW+1)'(prev_s_r) + (LW+1)'(prev_l_r) == (LW+1)'(key_r));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    words_nxt     = words_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    hlen_nxt      = hlen_r;
    uc_nxt        = uc_r;
    hc_nxt        = hc_r;
    wiu_nxt       = wiu_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    p_nxt         = p_r;
    cur_s_nxt     = cur_s_r;
    cur_l_nxt     = cur_l_r;
    prev_s_nxt    = prev_s_r;
    prev_l_nxt    = prev_l_r;
    has_cur_nxt   = has_cur_r;
    has_prev_nxt  = has_prev_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_idx        = idx_r;
    wr_en         = 1'b0;
    wr_idx        = p_r;
    wr_data       = {key_r, len_r};
    issue         = 1'b0;
    hit           = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_tuser;
          addr_nxt    = in_tdata[27:16];
          words_nxt   = words_in;
          granted_nxt = '0;
          idx_nxt     = '0;
          state_nxt   = in_tuser ? FSM_FADDR : FSM_CHECK;
        end
      end

      FSM_CHECK: begin
        state_nxt = FSM_RESP;
        if (uc_r >= CW'(TABLE_ENTRIES)) begin
          status_nxt = STAT_USED_FULL;
        end else if (words_r == '0) begin
          status_nxt = STAT_ZERO_SIZE;
        end else if (CMPW'(wiu_r) + CMPW'(words_r) > CMPW'(HEAP_WORDS)) begin
          status_nxt = STAT_EXCEEDED;
        end else begin
          len_nxt   = LW'(words_r);
          idx_nxt   = '0;
          state_nxt = FSM_FIT;
        end
      end

      // The four scans issue one read a cycle and test the entry of the previous read.
      FSM_FIT, FSM_UPOS, FSM_FADDR, FSM_HPOS: begin
        issue    = (idx_r < cnt);
        rd_en    = issue;
        pend_nxt = issue;
        pidx_nxt = idx_r;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        case (state_r)
          FSM_FIT:   hit = (CMPW'(rl) >= CMPW'(words_r));
          FSM_FADDR: hit = (AXW'(rs) == AXW'(addr_r));
          default:   hit = (rs > key_r);
        endcase
        if (pend_r && hit) begin
          pend_nxt = 1'b0;
          p_nxt    = pidx_r;
          case (state_r)
            FSM_FIT: begin
              key_nxt  = rs;
              hlen_nxt = rl;
              if (CMPW'(rl) > CMPW'(words_r)) begin
                state_nxt = FSM_TRIM;
              end else begin
                idx_nxt   = pidx_r + CW'(1);
                state_nxt = FSM_HREM;
              end
            end
            FSM_UPOS: begin
              idx_nxt   = uc_r;
              state_nxt = FSM_UINS;
            end
            FSM_FADDR: begin
              key_nxt   = rs;
              len_nxt   = rl;
              idx_nxt   = pidx_r + CW'(1);
              state_nxt = FSM_UREM;
            end
            default: begin
              cur_s_nxt    = rs;
              cur_l_nxt    = rl;
              has_cur_nxt  = 1'b1;
              has_prev_nxt = (pidx_r != '0);
              state_nxt    = FSM_MERGE;
            end
          endcase
        end else begin
          if (pend_r) begin
            prev_s_nxt = rs;
            prev_l_nxt = rl;
          end
          if (!pend_r && !issue) begin
            p_nxt = cnt;
            case (state_r)
              FSM_FIT: begin
                status_nxt = STAT_NO_FIT;
                state_nxt  = FSM_RESP;
              end
              FSM_UPOS: begin
                idx_nxt   = uc_r;
                state_nxt = FSM_UINS;
              end
              FSM_FADDR: begin
                status_nxt = STAT_UNKNOWN;
                state_nxt  = FSM_RESP;
              end
              default: begin
                has_cur_nxt  = 1'b0;
                has_prev_nxt = (hc_r != '0);
                state_nxt    = FSM_MERGE;
              end
            endcase
          end
        end
      end

      FSM_TRIM: begin
        wr_en     = 1'b1;
        wr_data   = {SW'((LW+1)'(key_r) + (LW+1)'(len_r)), LW'(hlen_r - len_r)};
        idx_nxt   = '0;
        state_nxt = FSM_UPOS;
      end

      // Removal: entries above the gap move down one place, one a cycle.
      FSM_HREM, FSM_UREM: begin
        issue    = (idx_r < cnt);
        rd_en    = issue;
        pend_nxt = issue;
        pidx_nxt = idx_r;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_idx  = pidx_r - CW'(1);
          wr_data = rdata;
        end
        if (!pend_r && !issue) begin
          idx_nxt = '0;
          if (state_r == FSM_HREM) begin
            hc_nxt    = hc_r - CW'(1);
            state_nxt = cmd_r ? FSM_RESP : FSM_UPOS;
          end else begin
            uc_nxt    = uc_r - CW'(1);
            wiu_nxt   = (wiu_r >= len_r) ? wiu_r - len_r : '0;
            state_nxt = FSM_HPOS;
          end
        end
      end

      // Insertion: entries from the top down to the position move up one place.
      FSM_UINS, FSM_HINS: begin
        issue    = (idx_r > p_r);
        rd_en    = issue;
        rd_idx   = idx_r - CW'(1);
        pend_nxt = issue;
        pidx_nxt = idx_r;
        if (issue) begin
          idx_nxt = idx_r - CW'(1);
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_idx  = pidx_r;
          wr_data = rdata;
        end
        if (!pend_r && !issue) begin
          wr_en      = 1'b1;
          wr_idx     = p_r;
          wr_data    = {key_r, len_r};
          status_nxt = STAT_OK;
          state_nxt  = FSM_RESP;
          if (state_r == FSM_UINS) begin
            uc_nxt      = uc_r + CW'(1);
            wiu_nxt     = wiu_r + len_r;
            granted_nxt = key_r;
          end else begin
            hc_nxt = hc_r + CW'(1);
          end
        end
      end

      FSM_MERGE: begin
        status_nxt = STAT_OK;
        state_nxt  = FSM_RESP;
        if (right_m && left_m) begin
          wr_en     = 1'b1;
          wr_idx    = p_r - CW'(1);
          wr_data   = {prev_s_r, LW'(prev_l_r + len_r + cur_l_r)};
          idx_nxt   = p_r + CW'(1);
          state_nxt = FSM_HREM;
        end else if (right_m) begin
          wr_en   = 1'b1;
          wr_data = {key_r, LW'(cur_l_r + len_r)};
        end else if (left_m) begin
          wr_en   = 1'b1;
          wr_idx  = p_r - CW'(1);
          wr_data = {prev_s_r, LW'(prev_l_r + len_r)};
        end else if (hc_r < CW'(TABLE_ENTRIES)) begin
          idx_nxt   = hc_r;
          state_nxt = FSM_HINS;
        end
      end

      FSM_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, 13'(wiu_r), 12'(granted_r), status_r};
          state_nxt     = FSM_IDLE;
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  assign h0v_nxt = h0v_r || (wr_en && sel_hole && (wr_idx[IW-1:0] == '0));

`ifndef SYNTHESIS
  // A shift never reads the entry it writes in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_idx != wr_idx))
    else $error("table read and write collide on one entry");

  // Between requests there is never more than one hole more than used blocks.
  a_hole_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_IDLE) |-> ((CW+1)'(hc_r) <= (CW+1)'(uc_r) + (CW+1)'(1)))
    else $error("hole table outgrew the used table");

  // The used table never holds more blocks than it has entries.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uc_r <= CW'(TABLE_ENTRIES))
    else $error("used table count out of range");
`endif

endmodule

>>> design/ffca_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing else.
module ffca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
